// ----- rtl/stsr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor timestamp realignment: shared types and constants
// Field widths, register indexes and the fixed time constants used by every
// module of the block.
// ----------------------------------------------------------------------------
package stsr_pkg;

    localparam int CNT_W       = 31;  // sensor counter
    localparam int HSEC_W      = 31;  // host seconds
    localparam int NS_W        = 30;  // nanoseconds within a second
    localparam int SEC_W       = 32;  // output seconds, two's complement
    localparam int CFG_W       = 31;  // configuration data
    localparam int CFG_INDEX_W = 2;
    localparam int SUM_W       = 35;  // wide enough for every biased sum
    localparam int MAX_QUOT    = 8;   // biased sum always stays below 9 s

    localparam logic [NS_W-1:0]  ONE_SEC_NS  = 30'd1000000000;
    localparam logic [NS_W-1:0]  HALF_SEC_NS = 30'd500000000;
    localparam logic [SUM_W-1:0] SUM_BIAS    = 35'd3000000000;
    localparam logic [SEC_W-1:0] SEC_MAX     = 32'h7FFF_FFFF;

    localparam logic [CFG_W-1:0] WRAP_MODULUS_RST = 31'd1048560000;
    localparam logic [CFG_W-1:0] NEAR_WRAP_RST    = 31'd1045000000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WRAP_MODULUS = 2'd0,
        CFG_NEAR_WRAP    = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] wrap_modulus;
        logic [CFG_W-1:0] near_wrap_threshold;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]  sample_counter;
        logic [HSEC_W-1:0] host_seconds;
        logic [NS_W-1:0]   host_nanoseconds;
    } item_t;

    typedef struct packed {
        logic [SEC_W-1:0] stamp_seconds;
        logic [NS_W-1:0]  stamp_nanoseconds;
        logic             counter_wrapped;
        logic             second_reset_seen;
    } result_t;

    // k whole seconds in nanoseconds, only ever called with a constant k.
    function automatic logic [SUM_W-1:0] sec_multiple(input int unsigned k);
        logic [SUM_W-1:0] m;
        m = SUM_W'(k) * SUM_W'(ONE_SEC_NS);
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/stsr_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor timestamp realignment: configuration registers
// Holds the wrap modulus and the near-wrap threshold written over the plain
// write port. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module stsr_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [stsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [stsr_pkg::CFG_W-1:0]     cfg_wdata,
    output stsr_pkg::cfg_t                      cfg
);
    import stsr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wrap_modulus        <= WRAP_MODULUS_RST;
            cfg_reg.near_wrap_threshold <= NEAR_WRAP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WRAP_MODULUS: cfg_reg.wrap_modulus        <= cfg_wdata;
                CFG_NEAR_WRAP:    cfg_reg.near_wrap_threshold <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- rtl/stsr_in_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor timestamp realignment: input register
// Captures one input beat and presents it to the core until the core takes it.
// ----------------------------------------------------------------------------
module stsr_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  stsr_pkg::item_t    s_item,
    input  wire logic          take,
    output logic               item_valid,
    output stsr_pkg::item_t    item
);
    import stsr_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // A new beat may enter in the same cycle as the held one leaves.
    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// ----- rtl/stsr_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor timestamp realignment: realignment core
// Classifies the counter step, accumulates nanoseconds modulo one second and
// chooses the output seconds. The running state updates when a beat is taken.
// ----------------------------------------------------------------------------
module stsr_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  stsr_pkg::cfg_t     cfg,
    input  stsr_pkg::item_t    item,
    input  wire logic          take,
    output stsr_pkg::result_t  res
);
    import stsr_pkg::*;

    logic [CNT_W-1:0] prev_counter_reg;
    logic [NS_W-1:0]  acc_reg;
    logic [SEC_W-1:0] prev_sec_reg;
    logic             wrap_armed_reg;
    logic             sensor_leads_reg;

    logic             wrap_armed_next;
    logic             sensor_leads_next;

    logic             armed_now;
    logic             backward;
    logic             wrapped;
    logic             reset_seen;
    logic [SUM_W-1:0] step;
    logic [SUM_W-1:0] acc_base;
    logic [SUM_W-1:0] biased;
    logic [SUM_W-1:0] rem_wide;
    logic [NS_W-1:0]  acc_new;
    logic [SEC_W-1:0] hs_ext;
    logic [SEC_W-1:0] hs_plus;
    logic [SEC_W-1:0] sec;
    logic             late;
    logic             early;
    logic             still_leading;
    logic             hns_high;

    assign armed_now  = wrap_armed_reg || (item.sample_counter > cfg.near_wrap_threshold);
    assign backward   = item.sample_counter < prev_counter_reg;
    assign wrapped    = backward && armed_now;
    assign reset_seen = backward && !armed_now;
    assign wrap_armed_next = backward ? 1'b0 : armed_now;

    // The step is held in two's complement; a wrap step goes negative when the
    // modulus plus the new counter is below the previous counter.
    always_comb begin
        if (wrapped) begin
            step = SUM_W'(item.sample_counter) + SUM_W'(cfg.wrap_modulus)
                 - SUM_W'(prev_counter_reg);
        end else if (reset_seen) begin
            step = SUM_W'(item.sample_counter);
        end else begin
            step = SUM_W'(item.sample_counter) - SUM_W'(prev_counter_reg);
        end
    end

    // A pulse reset restarts the accumulation from zero. The bias of three
    // seconds lifts the most negative sum above zero, so the remainder comes
    // from a row of constant compares.
    assign acc_base = reset_seen ? '0 : SUM_W'(acc_reg);
    assign biased   = acc_base + step + SUM_BIAS;

    always_comb begin
        rem_wide = biased;
        for (int unsigned k = 1; k <= MAX_QUOT; k++) begin
            if (biased >= sec_multiple(k)) begin
                rem_wide = biased - sec_multiple(k);
            end
        end
    end

    assign acc_new = rem_wide[NS_W-1:0];

    assign hs_ext        = {1'b0, item.host_seconds};
    assign hs_plus       = (&item.host_seconds) ? SEC_MAX : hs_ext + SEC_W'(1);
    assign hns_high      = item.host_nanoseconds > HALF_SEC_NS;
    assign late          = (hs_ext != prev_sec_reg) && (acc_new > HALF_SEC_NS);
    assign early         = (acc_new < acc_reg) && hns_high;
    assign still_leading = sensor_leads_reg && hns_high;

    always_comb begin
        priority if (late) begin
            sec               = hs_ext - SEC_W'(1);
            sensor_leads_next = 1'b0;
        end else if (early) begin
            sec               = hs_plus;
            sensor_leads_next = 1'b1;
        end else if (still_leading) begin
            sec               = hs_plus;
            sensor_leads_next = 1'b1;
        end else begin
            sec               = hs_ext;
            sensor_leads_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_counter_reg <= '0;
            acc_reg          <= '0;
            prev_sec_reg     <= '0;
            wrap_armed_reg   <= 1'b0;
            sensor_leads_reg <= 1'b0;
        end else if (take) begin
            prev_counter_reg <= item.sample_counter;
            acc_reg          <= acc_new;
            prev_sec_reg     <= sec;
            wrap_armed_reg   <= wrap_armed_next;
            sensor_leads_reg <= sensor_leads_next;
        end
    end

    assign res.stamp_seconds     = sec;
    assign res.stamp_nanoseconds = acc_new;
    assign res.counter_wrapped   = wrapped;
    assign res.second_reset_seen = reset_seen;

endmodule
`default_nettype wire

// ----- rtl/stsr_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor timestamp realignment: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module stsr_out_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    input  stsr_pkg::result_t  res,
    output logic               out_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output stsr_pkg::result_t  m_res
);
    import stsr_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign out_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule
`default_nettype wire

// ----- rtl/sensor_timestamp_realign.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor timestamp realignment: top level
// Rebuilds a timestamp from a sensor nanosecond counter and the host clock.
// ----------------------------------------------------------------------------
// Each input beat gives exactly one result beat. The block takes one beat per
// clock cycle while the result side does not stall. Each beat is held first
// in the input register, where the counter step, the modulo-one-second
// accumulation and the seconds choice are worked out in a single pass against
// the running state, and then in the result register. Throughput is set by
// that state update, which is registered as the beat moves on. Configuration
// must only be written while no beat is in flight.
module sensor_timestamp_realign (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [stsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [stsr_pkg::CFG_W-1:0]        cfg_wdata,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [stsr_pkg::CNT_W-1:0]        s_sample_counter,
    input  wire logic [stsr_pkg::HSEC_W-1:0]       s_host_seconds,
    input  wire logic [stsr_pkg::NS_W-1:0]         s_host_nanoseconds,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [stsr_pkg::SEC_W-1:0]      m_stamp_seconds,
    output logic [stsr_pkg::NS_W-1:0]              m_stamp_nanoseconds,
    output logic                                   m_counter_wrapped,
    output logic                                   m_second_reset_seen
);
    import stsr_pkg::*;

    cfg_t    cfg;
    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_ready;
    logic    take;
    result_t res;
    result_t m_res;

    assign s_item.sample_counter   = s_sample_counter;
    assign s_item.host_seconds     = s_host_seconds;
    assign s_item.host_nanoseconds = s_host_nanoseconds;

    assign take = item_valid && out_ready;

    stsr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    stsr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    stsr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item),
        .take    (take),
        .res     (res)
    );

    stsr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take),
        .res       (res),
        .out_ready (out_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_stamp_seconds     = m_res.stamp_seconds;
    assign m_stamp_nanoseconds = m_res.stamp_nanoseconds;
    assign m_counter_wrapped   = m_res.counter_wrapped;
    assign m_second_reset_seen = m_res.second_reset_seen;

endmodule
`default_nettype wire

// ----- rtl/stsr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor timestamp realignment: port checker
// Watches the top-level ports and flags result beats that break the block's
// guarantees.
// ----------------------------------------------------------------------------
module stsr_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic signed [stsr_pkg::SEC_W-1:0] m_stamp_seconds,
    input  wire logic [stsr_pkg::NS_W-1:0]         m_stamp_nanoseconds,
    input  wire logic                              m_counter_wrapped,
    input  wire logic                              m_second_reset_seen
);
    import stsr_pkg::*;

    // Nothing can come out in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_stamp_seconds)
            && $stable(m_stamp_nanoseconds) && $stable(m_counter_wrapped)
            && $stable(m_second_reset_seen))
        else $error("stalled result beat changed");

    a_ns_in_second: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_stamp_nanoseconds < ONE_SEC_NS)
        else $error("nanoseconds reached one second");

    a_one_step_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_counter_wrapped && m_second_reset_seen))
        else $error("step taken as both wrap and pulse reset");

    a_seconds_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stamp_seconds[SEC_W-1] |-> (&m_stamp_seconds))
        else $error("seconds below minus one");

endmodule

bind sensor_timestamp_realign stsr_checker u_stsr_checker (.*);
`default_nettype wire
